@@ src/sweep_active_interval_pairs_defines.svh @@
// Assertion macros used by the checker of the sweep pair reporter.
`ifndef SWEEP_ACTIVE_INTERVAL_PAIRS_DEFINES_SVH
`define SWEEP_ACTIVE_INTERVAL_PAIRS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sai_pkg.sv @@
// Package: types and constants of the sweep-line interval pair reporter.
package sai_pkg;

    localparam int ID_W              = 10;
    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int ACTIVE_MAX_DEF    = 64;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_END   = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] interval_id;
    } sai_evt_t;

    typedef struct packed {
        logic [ID_W-1:0] new_id;
        logic [ID_W-1:0] other_id;
        logic            last;
        logic            dropped;
    } sai_pair_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_write;
        logic capture;
        logic insert;
        logic start_pairs;
        logic hold_pairs;
        logic pair_step;
        logic read_tail;
        logic move;
        logic retire;
    } sai_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic id_ok;
        logic is_end;
        logic hit;
        logic list_empty;
        logic list_full;
        logic slot_ok;
        logic out_free;
        logic pair_last;
    } sai_sts_t;

endpackage

@@ src/sai_ctrl.sv @@
// Controller: state machine that sequences clearing, lookup, pair output and removal.
module sai_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_stall,
    input  sai_pkg::sai_sts_t sts,
    output sai_pkg::sai_cmd_t cmd
);

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOK   = 3'd2;
    localparam logic [2:0] ST_PAIRS  = 3'd3;
    localparam logic [2:0] ST_MOVE   = 3'd4;
    localparam logic [2:0] ST_RETIRE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign evt_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                if (sts.id_ok)
                begin
                    if (sts.is_end)
                    begin
                        if (sts.hit && sts.slot_ok)
                        begin
                            cmd.read_tail = 1'b1;
                            state_next    = ST_MOVE;
                        end
                    end
                    else if (!sts.hit)
                    begin
                        if (sts.list_empty)
                        begin
                            cmd.insert = 1'b1;
                        end
                        else
                        begin
                            cmd.start_pairs = 1'b1;
                            state_next      = ST_PAIRS;
                        end
                    end
                end
            end
            ST_PAIRS:
            begin
                cmd.hold_pairs = 1'b1;
                if (sts.out_free)
                begin
                    cmd.pair_step = 1'b1;
                    if (sts.pair_last)
                    begin
                        cmd.insert = !sts.list_full;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = ST_RETIRE;
            end
            ST_RETIRE:
            begin
                cmd.retire = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/sai_dp.sv @@
// Datapath: slot map memory, active list memory, counters and the pair output register.
module sai_dp #(
    parameter int MAX_INTERVALS = sai_pkg::MAX_INTERVALS_DEF,
    parameter int ACTIVE_MAX    = sai_pkg::ACTIVE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sai_pkg::sai_evt_t  evt_data,
    input  sai_pkg::sai_cmd_t  cmd,
    output sai_pkg::sai_sts_t  sts,
    output logic               pair_valid,
    input  logic               pair_stall,
    output sai_pkg::sai_pair_t pair_data
);

    localparam int ID_W   = sai_pkg::ID_W;
    localparam int IDX_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int SLOT_W = (ACTIVE_MAX > 1) ? $clog2(ACTIVE_MAX) : 1;
    localparam int CNT_W  = $clog2(ACTIVE_MAX + 1);
    localparam int EXT_W  = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
    localparam int ENT_W  = SLOT_W + 1;

    // Slot map entry: {active, slot}
    logic [ENT_W-1:0]  slot_mem [MAX_INTERVALS];
    logic [ID_W-1:0]   list_mem [ACTIVE_MAX];

    logic              ev_cmd_reg;
    logic [ID_W-1:0]   ev_id_reg;
    logic              ev_ok_reg;
    logic [ENT_W-1:0]  ent_rd_reg;
    logic [ID_W-1:0]   list_rd_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] k_reg;
    logic [SLOT_W-1:0] k_next;
    logic [IDX_W-1:0]  clr_reg;
    logic [IDX_W-1:0]  clr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sai_pkg::sai_pair_t out_data_reg;

    logic [EXT_W-1:0]  in_ext;
    logic              in_ok;
    logic [IDX_W-1:0]  in_idx;
    logic [EXT_W-1:0]  ev_ext;
    logic [IDX_W-1:0]  ev_idx;
    logic [EXT_W-1:0]  moved_ext;
    logic              moved_ok;
    logic [IDX_W-1:0]  moved_idx;
    logic              ent_active;
    logic [SLOT_W-1:0] ent_slot;
    logic              list_full;
    logic              pair_last;

    logic              sm_we;
    logic [IDX_W-1:0]  sm_addr;
    logic [ENT_W-1:0]  sm_wdata;
    logic              lm_we;
    logic [SLOT_W-1:0] lm_waddr;
    logic [ID_W-1:0]   lm_wdata;
    logic              lm_re;
    logic [SLOT_W-1:0] lm_raddr;

    assign in_ext    = EXT_W'(evt_data.interval_id);
    assign in_ok     = (in_ext < EXT_W'(MAX_INTERVALS));
    assign in_idx    = in_ext[IDX_W-1:0];
    assign ev_ext    = EXT_W'(ev_id_reg);
    assign ev_idx    = ev_ext[IDX_W-1:0];
    assign moved_ext = EXT_W'(list_rd_reg);
    assign moved_ok  = (moved_ext < EXT_W'(MAX_INTERVALS));
    assign moved_idx = moved_ext[IDX_W-1:0];

    assign ent_active = ent_rd_reg[SLOT_W];
    assign ent_slot   = ent_rd_reg[SLOT_W-1:0];
    assign list_full  = (count_reg == CNT_W'(ACTIVE_MAX));
    assign pair_last  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        sts.clear_done = (clr_reg == IDX_W'(MAX_INTERVALS - 1));
        sts.id_ok      = ev_ok_reg;
        sts.is_end     = (ev_cmd_reg == sai_pkg::CMD_END);
        sts.hit        = ent_active;
        sts.list_empty = (count_reg == '0);
        sts.list_full  = list_full;
        sts.slot_ok    = (CNT_W'(ent_slot) < count_reg);
        sts.out_free   = !out_valid_reg || !pair_stall;
        sts.pair_last  = pair_last;
    end

    // Slot map write port
    always_comb
    begin
        sm_we    = 1'b0;
        sm_addr  = clr_reg;
        sm_wdata = '0;
        if (cmd.clr_write)
        begin
            sm_we = 1'b1;
        end
        else if (cmd.insert)
        begin
            sm_we    = 1'b1;
            sm_addr  = ev_idx;
            sm_wdata = {1'b1, SLOT_W'(count_reg)};
        end
        else if (cmd.move)
        begin
            sm_we    = moved_ok;
            sm_addr  = moved_idx;
            sm_wdata = {1'b1, ent_slot};
        end
        else if (cmd.retire)
        begin
            sm_we    = 1'b1;
            sm_addr  = ev_idx;
            sm_wdata = {1'b0, ent_slot};
        end
    end

    // Active list write and read ports
    always_comb
    begin
        lm_we    = cmd.insert || cmd.move;
        lm_waddr = cmd.move ? ent_slot : SLOT_W'(count_reg);
        lm_wdata = cmd.move ? list_rd_reg : ev_id_reg;
        lm_re    = cmd.start_pairs || cmd.hold_pairs || cmd.read_tail;
        if (cmd.read_tail)
        begin
            lm_raddr = SLOT_W'(count_reg - CNT_W'(1));
        end
        else if (cmd.hold_pairs && cmd.pair_step && !pair_last)
        begin
            lm_raddr = k_reg + SLOT_W'(1);
        end
        else if (cmd.hold_pairs)
        begin
            lm_raddr = k_reg;
        end
        else
        begin
            lm_raddr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            slot_mem[sm_addr] <= sm_wdata;
        end
        if (cmd.capture)
        begin
            ent_rd_reg <= slot_mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lm_we)
        begin
            list_mem[lm_waddr] <= lm_wdata;
        end
        if (lm_re)
        begin
            list_rd_reg <= list_mem[lm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_cmd_reg <= evt_data.cmd;
            ev_id_reg  <= evt_data.interval_id;
            ev_ok_reg  <= in_ok;
        end
        if (cmd.pair_step)
        begin
            out_data_reg.new_id   <= ev_id_reg;
            out_data_reg.other_id <= list_rd_reg;
            out_data_reg.last     <= pair_last;
            out_data_reg.dropped  <= pair_last && list_full;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.move)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        k_next = k_reg;
        if (cmd.start_pairs)
        begin
            k_next = '0;
        end
        else if (cmd.pair_step)
        begin
            k_next = k_reg + SLOT_W'(1);
        end

        clr_next = cmd.clr_write ? (clr_reg + IDX_W'(1)) : clr_reg;

        out_valid_next = out_valid_reg;
        if (cmd.pair_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pair_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            k_reg         <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            k_reg         <= k_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pair_valid = out_valid_reg;
    assign pair_data  = out_data_reg;

endmodule

@@ src/sweep_active_interval_pairs.sv @@
// Top level: sweep-line interval pair reporter, controller plus datapath.
//
// Sweep-line interval pair reporter. Feed begin/end events for numbered
// intervals, already sorted by position, on the evt channel; every begin of an
// inactive interval returns one transfer on the pair channel for each interval
// active at that moment, in active-list order, with last set on the final one.
// When the list already holds ACTIVE_MAX entries the pairs are still reported,
// the new interval is not inserted, and dropped is set on the final pair.
// Duplicate begins, ends of inactive intervals and ids at or above
// MAX_INTERVALS produce nothing. After reset the block clears its slot map,
// one entry per cycle, with evt_stall held high. Then each event is captured
// and looked up; an end of an active interval moves the list tail into its
// slot and retires the interval, and a begin that finds active intervals emits
// its pairs. The single read port of the active list, one entry per cycle
// unless pair_stall holds the output, sets the pair rate. A finished pair waits
// in the output register, so the next event can be taken while it is pending.
module sweep_active_interval_pairs #(
    parameter int MAX_INTERVALS = sai_pkg::MAX_INTERVALS_DEF,
    parameter int ACTIVE_MAX    = sai_pkg::ACTIVE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               evt_valid,
    output logic               evt_stall,
    input  sai_pkg::sai_evt_t  evt_data,
    output logic               pair_valid,
    input  logic               pair_stall,
    output sai_pkg::sai_pair_t pair_data
);

    sai_pkg::sai_cmd_t cmd;
    sai_pkg::sai_sts_t sts;

    // Sequence clear, lookup, pair output and removal
    sai_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the slot map, the active list and the pair output register
    sai_dp #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .ACTIVE_MAX    (ACTIVE_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_data   (evt_data),
        .cmd        (cmd),
        .sts        (sts),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_data  (pair_data)
    );

endmodule

@@ src/sai_chk.sv @@
// Checker: port-level assertions for the sweep pair reporter, bound to the top level.
`include "sweep_active_interval_pairs_defines.svh"

module sai_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               evt_valid,
    input logic               evt_stall,
    input sai_pkg::sai_evt_t  evt_data,
    input logic               pair_valid,
    input logic               pair_stall,
    input sai_pkg::sai_pair_t pair_data
);

    `SAI_ASSERT_NEXT(a_pair_hold, clk, rst_n, pair_valid && pair_stall, pair_valid && $stable(pair_data), "stalled pair changed")
    `SAI_ASSERT_NOW(a_drop_on_last, clk, rst_n, pair_valid && pair_data.dropped, pair_data.last, "dropped set on a pair that is not last")
    `SAI_ASSERT_NEXT(a_evt_busy, clk, rst_n, evt_valid && !evt_stall, evt_stall, "event taken back to back")
    `SAI_ASSERT_NEXT(a_burst_same_new, clk, rst_n, pair_valid && !pair_stall && !pair_data.last, pair_valid && (pair_data.new_id == $past(pair_data.new_id)), "pair burst broken or new_id changed")

endmodule

bind sweep_active_interval_pairs sai_chk u_chk (.*);

@@ tb/sv/sweep_active_interval_pairs_tb.sv @@
// Self-checking testbench for the sweep-line interval pair reporter.
module sweep_active_interval_pairs_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Local names for the package items used throughout the bench.
    localparam int   ID_W              = sai_pkg::ID_W;
    localparam int   ACTIVE_MAX_DEF    = sai_pkg::ACTIVE_MAX_DEF;
    localparam int   MAX_INTERVALS_DEF = sai_pkg::MAX_INTERVALS_DEF;
    localparam logic CMD_BEGIN         = sai_pkg::CMD_BEGIN;
    localparam logic CMD_END           = sai_pkg::CMD_END;

    typedef sai_pkg::sai_evt_t  sai_evt_t;
    typedef sai_pkg::sai_pair_t sai_pair_t;

    // Scale of the run. The watchdog allows for the slot-map clearing pass
    // after reset plus every event emitting a full list of stalled pairs.
    localparam int RANDOM_EVENTS = 448;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int CHOKE_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int DIR_ROWS      = 22;

    logic      clk;
    logic      rst_n;
    logic      evt_valid;
    logic      evt_stall;
    sai_evt_t  evt_data;
    logic      pair_valid;
    logic      pair_stall;
    sai_pair_t pair_data;

    sweep_active_interval_pairs u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair_data  (pair_data)
    );

    // Shadow of the block's active list: list in slot order, the slot of each
    // live interval, its live flag and the list length.
    logic [ID_W-1:0] live_list [ACTIVE_MAX_DEF];
    logic [5:0]      live_slot [MAX_INTERVALS_DEF];
    bit              live_flag [MAX_INTERVALS_DEF];
    int              live_count = 0;

    // Pairs the block still owes, oldest first.
    sai_pair_t owed_pairs [$];

    // Run statistics and shared controls. Each is written by one process only.
    int mismatches    = 0;
    int checked_pairs = 0;
    int refusals_seen = 0;
    int begins_done   = 0;
    int ends_done     = 0;
    int ignored_evts  = 0;
    int counted       = 0;
    int choke_request = 0;
    bit steady        = 1'b0;

    // One row of the directed part. Rows with typed set carry their result:
    // either nothing, or exactly the single pair given; other rows fall back
    // to the shadow model.
    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] id;
        logic            typed;
        logic            one_pair;
        sai_pair_t       pair;
    } dir_row_t;

    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{CMD_BEGIN, 10'd0,    1'b1, 1'b0, '0},                        // empty list
        '{CMD_BEGIN, 10'd0,    1'b1, 1'b0, '0},                        // duplicate begin
        '{CMD_END,   10'd1023, 1'b1, 1'b0, '0},                        // end of idle id
        '{CMD_BEGIN, 10'd1023, 1'b1, 1'b1, '{10'd1023, 10'd0, 1'b1, 1'b0}},
        '{CMD_BEGIN, 10'd341,  1'b0, 1'b0, '0},
        '{CMD_BEGIN, 10'd682,  1'b0, 1'b0, '0},
        '{CMD_BEGIN, 10'd512,  1'b0, 1'b0, '0},
        '{CMD_BEGIN, 10'd1023, 1'b1, 1'b0, '0},                        // duplicate, busy list
        '{CMD_END,   10'd0,    1'b0, 1'b0, '0},                        // tail moves to head
        '{CMD_BEGIN, 10'd1,    1'b0, 1'b0, '0},
        '{CMD_END,   10'd512,  1'b0, 1'b0, '0},
        '{CMD_END,   10'd512,  1'b1, 1'b0, '0},                        // already ended
        '{CMD_BEGIN, 10'd0,    1'b0, 1'b0, '0},
        '{CMD_END,   10'd1,    1'b0, 1'b0, '0},
        '{CMD_END,   10'd1023, 1'b0, 1'b0, '0},
        '{CMD_END,   10'd341,  1'b0, 1'b0, '0},                        // end of the tail
        '{CMD_END,   10'd682,  1'b0, 1'b0, '0},
        '{CMD_END,   10'd0,    1'b0, 1'b0, '0},                        // list empty again
        '{CMD_BEGIN, 10'd1022, 1'b1, 1'b0, '0},
        '{CMD_BEGIN, 10'd1,    1'b1, 1'b1, '{10'd1, 10'd1022, 1'b1, 1'b0}},
        '{CMD_END,   10'd1,    1'b0, 1'b0, '0},
        '{CMD_END,   10'd1022, 1'b0, 1'b0, '0}
    };

    // Idle cycles before the next transfer on either side; none in steady runs.
    function automatic int draw_wait();
        if (steady)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Draw an interval number that is not live right now.
    function automatic logic [ID_W-1:0] pick_idle_id();
        logic [ID_W-1:0] id;
        do
        begin
            id = ID_W'($urandom_range(0, MAX_INTERVALS_DEF - 1));
        end
        while (live_flag[id]);
        return id;
    endfunction

    // Append one pair to the tail of the owed queue.
    task automatic owe_pair(input sai_pair_t p);
        owed_pairs.insert(owed_pairs.size(), p);
    endtask

    // Advance the shadow list by one accepted event; queue the pairs it owes
    // when keep is set.
    task automatic apply_sweep_event(input sai_evt_t ev, input bit keep,
                                     output int n_pairs, output bit ignored);
        sai_pair_t       p;
        logic [5:0]      hole;
        logic [ID_W-1:0] moved;
        bit              full;
        n_pairs = 0;
        ignored = 1'b0;
        if (ev.cmd == CMD_BEGIN)
        begin
            if (live_flag[ev.interval_id])
            begin
                ignored = 1'b1;
            end
            else
            begin
                full = (live_count >= ACTIVE_MAX_DEF);
                for (int k = 0; k < live_count; k++)
                begin
                    p.new_id   = ev.interval_id;
                    p.other_id = live_list[k];
                    p.last     = (k == live_count - 1);
                    p.dropped  = full && (k == live_count - 1);
                    if (keep)
                        owe_pair(p);
                    n_pairs++;
                end
                if (!full)
                begin
                    live_list[live_count]      = ev.interval_id;
                    live_slot[ev.interval_id]  = 6'(live_count);
                    live_flag[ev.interval_id]  = 1'b1;
                    live_count++;
                end
            end
        end
        else
        begin
            if (!live_flag[ev.interval_id])
            begin
                ignored = 1'b1;
            end
            else
            begin
                // Fill the hole with the tail entry and shrink the list.
                hole             = live_slot[ev.interval_id];
                moved            = live_list[live_count - 1];
                live_list[hole]  = moved;
                live_slot[moved] = hole;
                live_flag[ev.interval_id] = 1'b0;
                live_count--;
            end
        end
    endtask

    // Offer one event after a random gap, hold it until the transfer, then
    // update the shadow list. Valid stays high so a zero gap runs back to back.
    task automatic send_event(input logic cmd, input logic [ID_W-1:0] id, input bit keep);
        int       gap;
        int       n_pairs;
        bit       ignored;
        sai_evt_t ev;
        ev.cmd         = cmd;
        ev.interval_id = id;
        gap = draw_wait();
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt_data  <= ev;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        apply_sweep_event(ev, keep, n_pairs, ignored);
        if (ignored)
            ignored_evts++;
        else if (cmd == CMD_BEGIN)
            begins_done++;
        else
            ends_done++;
        counted++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up if the run hangs.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sweep_active_interval_pairs verification failed");
        $finish;
    end

    // Pair sink: check each transfer against the oldest owed pair, then draw
    // the next stall. A choke request holds the output off for a long stretch
    // so the block backs up into its event input.
    initial
    begin : pair_sink
        int        hold_left;
        int        choke_left;
        int        chokes_served;
        sai_pair_t want;
        hold_left     = 0;
        choke_left    = 0;
        chokes_served = 0;
        pair_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pair_valid && !pair_stall)
            begin
                checked_pairs++;
                if (pair_data.dropped)
                    refusals_seen++;
                if (owed_pairs.size() == 0)
                begin
                    $error("unexpected pair: new_id %0d other_id %0d",
                           pair_data.new_id, pair_data.other_id);
                    mismatches++;
                end
                else
                begin
                    want = owed_pairs.pop_front();
                    if (pair_data.new_id !== want.new_id)
                    begin
                        $error("new_id: expected %0d, got %0d", want.new_id, pair_data.new_id);
                        mismatches++;
                    end
                    if (pair_data.other_id !== want.other_id)
                    begin
                        $error("other_id: expected %0d, got %0d",
                               want.other_id, pair_data.other_id);
                        mismatches++;
                    end
                    if (pair_data.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, pair_data.last);
                        mismatches++;
                    end
                    if (pair_data.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0d, got %0d", want.dropped, pair_data.dropped);
                        mismatches++;
                    end
                end
                hold_left = draw_wait();
            end
            if (choke_request > chokes_served)
            begin
                chokes_served++;
                choke_left = CHOKE_CYCLES;
            end
            if (choke_left > 0)
            begin
                choke_left--;
                pair_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                pair_stall <= 1'b1;
            end
            else
            begin
                pair_stall <= 1'b0;
            end
        end
    end

    // Event source: reset, directed table, then random sweeps.
    initial
    begin : event_source
        int              level;
        int              next_level_at;
        int              roll;
        bit              full_done;
        bit              choke_done;
        bit              pause_done;
        logic [ID_W-1:0] refused_id;

        rst_n     <= 1'b0;
        evt_valid <= 1'b0;
        evt_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: walk the table. Typed rows still advance the shadow
        // list, but their result comes from the table itself.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_event(dir_tbl[r].cmd, dir_tbl[r].id, !dir_tbl[r].typed);
            if (dir_tbl[r].typed && dir_tbl[r].one_pair)
                owe_pair(dir_tbl[r].pair);
        end

        // Random part: mostly well-formed sweeps that hover around a drifting
        // number of live intervals, with some noise mixed in.
        counted       = 0;
        level         = 0;
        next_level_at = 0;
        full_done     = 1'b0;
        choke_done    = 1'b0;
        pause_done    = 1'b0;
        while (counted < RANDOM_EVENTS)
        begin
            if (counted >= next_level_at)
            begin
                next_level_at += 40;
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    level = $urandom_range(0, 6);
                else if (roll < 9)
                    level = $urandom_range(7, 16);
                else
                    level = $urandom_range(17, 32);
                steady = ($urandom_range(0, 3) == 0);
            end

            // Choke the output while events keep coming.
            if (!choke_done && counted >= 150)
            begin
                choke_done = 1'b1;
                choke_request++;
            end

            // Fill the list to the brim, overflow it, then drain it.
            if (!full_done && counted >= 250)
            begin
                full_done = 1'b1;
                while (live_count < ACTIVE_MAX_DEF)
                    send_event(CMD_BEGIN, pick_idle_id(), 1'b1);
                refused_id = pick_idle_id();
                send_event(CMD_BEGIN, refused_id, 1'b1);
                send_event(CMD_BEGIN, live_list[$urandom_range(0, live_count - 1)], 1'b1);
                send_event(CMD_END, refused_id, 1'b1);
                send_event(CMD_END, live_list[$urandom_range(0, live_count - 1)], 1'b1);
                send_event(CMD_BEGIN, refused_id, 1'b1);
                send_event(CMD_BEGIN, pick_idle_id(), 1'b1);
                while (live_count > 0)
                    send_event(CMD_END, live_list[$urandom_range(0, live_count - 1)], 1'b1);
            end

            // Hold the input until every owed pair is in, then let any
            // resultless event finish inside the block.
            if (!pause_done && counted >= 380)
            begin
                pause_done = 1'b1;
                evt_valid <= 1'b0;
                @(posedge clk);
                while (owed_pairs.size() != 0)
                    @(posedge clk);
                repeat (8) @(posedge clk);
            end

            roll = $urandom_range(0, 7);
            if (roll == 0)
            begin
                // Noise: duplicate begins, ends of idle ids, anything at all.
                case ($urandom_range(0, 2))
                    0: send_event(CMD_BEGIN, (live_count > 0) ?
                                  live_list[$urandom_range(0, live_count - 1)] :
                                  ID_W'($urandom_range(0, MAX_INTERVALS_DEF - 1)), 1'b1);
                    1: send_event(CMD_END, pick_idle_id(), 1'b1);
                    default: send_event(1'($urandom_range(0, 1)),
                                        ID_W'($urandom_range(0, MAX_INTERVALS_DEF - 1)), 1'b1);
                endcase
            end
            else if (live_count == 0 || (live_count < level && roll > 1) ||
                     (live_count >= level && roll == 1))
            begin
                send_event(CMD_BEGIN, pick_idle_id(), 1'b1);
            end
            else
            begin
                send_event(CMD_END, live_list[$urandom_range(0, live_count - 1)], 1'b1);
            end
        end

        // Drain: drop valid, collect every owed pair, then watch a few more
        // cycles for stray transfers.
        steady = 1'b0;
        evt_valid <= 1'b0;
        @(posedge clk);
        while (owed_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d begins, %0d ends and %0d ignored events;",
                 begins_done, ends_done, ignored_evts);
        $display("%0d pairs checked, %0d of them refused on a full list.",
                 checked_pairs, refusals_seen);
        if (mismatches == 0)
            $display("sweep_active_interval_pairs verification clean");
        else
            $display("sweep_active_interval_pairs verification failed");
        $finish;
    end

endmodule
